@@ design/rau_pkg.sv @@
// ----------------------------------------------------------------------------
// rau_pkg: shared types and constants for the rational arithmetic unit
// Operation and status codes, field widths, controller/datapath handshake.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

  // Field widths on the ports
  localparam int FIELD_W      = 32;
  localparam int FUNC_W       = 3;
  localparam int STATUS_W     = 2;
  localparam int MAG_W        = 64;
  localparam int DEN_W        = MAG_W - 1;
  localparam int SHIFT_W      = $clog2(MAG_W);
  localparam int IN_DATA_W    = 4 * FIELD_W;
  localparam int OUT_DATA_W   = 128;
  localparam int OPERAND_WIDTH_DEF = 32;

  // Operation codes
  localparam logic [FUNC_W-1:0] FUNC_ADD  = 3'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUB  = 3'd1;
  localparam logic [FUNC_W-1:0] FUNC_MUL  = 3'd2;
  localparam logic [FUNC_W-1:0] FUNC_DIV  = 3'd3;

  // Status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_ZERO_DEN = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OVF      = 2'd2;

  // Multiply steps
  localparam int MUL_IDX_W = 2;
  localparam logic [MUL_IDX_W-1:0] MUL_P1  = 2'd0;
  localparam logic [MUL_IDX_W-1:0] MUL_P2  = 2'd1;
  localparam logic [MUL_IDX_W-1:0] MUL_DEN = 2'd2;

  // Controller to datapath commands
  typedef struct packed {
    logic                 load;
    logic                 mul_en;
    logic [MUL_IDX_W-1:0] mul_idx;
    logic                 sum_en;
    logic                 gcd_init;
    logic                 gcd_en;
    logic                 div_init;
    logic                 div_en;
    logic                 out_load;
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic is_show;
    logic den_zero;
    logic gcd_done;
    logic div_last;
    logic out_busy;
  } sts_t;

endpackage

`default_nettype wire

@@ design/rau_ctrl.sv @@
// ----------------------------------------------------------------------------
// rau_ctrl: sequencing state machine
// Steps the datapath: multiply, sum, GCD, divide (not for show/zero den), load.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl (
  input  wire                 clk,
  input  wire                 rst,
  input  wire                 in_valid,
  output logic                in_ready,
  input  wire rau_pkg::sts_t  sts,
  output rau_pkg::cmd_t       cmd
);
  import rau_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE, S_MUL, S_SUM, S_CHECK, S_GCD, S_DIV, S_OUT
  } state_t;

  state_t               state, state_next;
  logic [MUL_IDX_W-1:0] mul_idx, mul_idx_next;

  // Next state and commands
  always_comb begin
    state_next   = state;
    mul_idx_next = mul_idx;
    cmd          = '0;
    cmd.mul_idx  = mul_idx;
    in_ready     = 1'b0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load     = 1'b1;
          mul_idx_next = MUL_P1;
          state_next   = S_MUL;
        end
      end
      S_MUL: begin
        cmd.mul_en = 1'b1;
        if (mul_idx == MUL_DEN) begin
          state_next = S_SUM;
        end else begin
          mul_idx_next = mul_idx + 1'b1;
        end
      end
      S_SUM: begin
        cmd.sum_en = 1'b1;
        state_next = S_CHECK;
      end
      S_CHECK: begin
        if (sts.is_show || sts.den_zero) begin
          state_next = S_OUT;
        end else begin
          cmd.gcd_init = 1'b1;
          state_next   = S_GCD;
        end
      end
      S_GCD: begin
        if (sts.gcd_done) begin
          cmd.div_init = 1'b1;
          state_next   = S_DIV;
        end else begin
          cmd.gcd_en = 1'b1;
        end
      end
      S_DIV: begin
        cmd.div_en = 1'b1;
        if (sts.div_last) state_next = S_OUT;
      end
      S_OUT: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= S_IDLE;
      mul_idx <= MUL_P1;
    end else begin
      state   <= state_next;
      mul_idx <= mul_idx_next;
    end
  end

endmodule

`default_nettype wire

@@ design/rau_dp.sv @@
// ----------------------------------------------------------------------------
// rau_dp: arithmetic datapath
// Operand registers, shared multiplier, signed sum, binary GCD, two restoring
// dividers and the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                               clk,
  input  wire                               rst,
  input  wire [rau_pkg::FUNC_W-1:0]         in_func,
  input  wire [rau_pkg::IN_DATA_W-1:0]      in_data,
  input  wire rau_pkg::cmd_t                cmd,
  output rau_pkg::sts_t                     sts,
  output logic                              out_valid,
  input  wire                               out_ready,
  output logic [rau_pkg::OUT_DATA_W-1:0]    out_data,
  output logic [rau_pkg::STATUS_W-1:0]      out_user
);
  import rau_pkg::*;

  localparam int OW = OPERAND_WIDTH;
  localparam int PW = 2 * OPERAND_WIDTH;

  // Operand registers, sign and magnitude
  logic [FUNC_W-1:0] func_r;
  logic              an_neg, ad_neg, bn_neg, bd_neg;
  logic [OW-1:0]     an_mag, ad_mag, bn_mag, bd_mag;
  logic [OW-1:0]     an_f, ad_f, bn_f, bd_f;

  assign an_f = in_data[OW-1:0];
  assign ad_f = in_data[FIELD_W +: OW];
  assign bn_f = in_data[2*FIELD_W +: OW];
  assign bd_f = in_data[3*FIELD_W +: OW];

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_r <= in_func;
      an_neg <= an_f[OW-1];
      ad_neg <= ad_f[OW-1];
      bn_neg <= bn_f[OW-1];
      bd_neg <= bd_f[OW-1];
      an_mag <= an_f[OW-1] ? -an_f : an_f;
      ad_mag <= ad_f[OW-1] ? -ad_f : ad_f;
      bn_mag <= bn_f[OW-1] ? -bn_f : bn_f;
      bd_mag <= bd_f[OW-1] ? -bd_f : bd_f;
    end
  end

  logic is_addsub;
  assign is_addsub = (func_r == FUNC_ADD) || (func_r == FUNC_SUB);

  // Shared multiplier: operand pair chosen by step and operation
  logic [OW-1:0]    mx, my;
  logic             mx_neg, my_neg;
  logic [PW-1:0]    prod_full;
  logic [MAG_W-1:0] prod;
  logic             prod_neg;

  always_comb begin
    case (cmd.mul_idx)
      MUL_P1: begin
        mx = an_mag; mx_neg = an_neg;
        if (func_r == FUNC_MUL) begin
          my = bn_mag; my_neg = bn_neg;
        end else begin
          my = bd_mag; my_neg = bd_neg;
        end
      end
      MUL_P2: begin
        mx = ad_mag; mx_neg = ad_neg;
        my = bn_mag; my_neg = bn_neg;
      end
      default: begin
        mx = ad_mag; mx_neg = ad_neg;
        if (func_r == FUNC_DIV) begin
          my = bn_mag; my_neg = bn_neg;
        end else begin
          my = bd_mag; my_neg = bd_neg;
        end
      end
    endcase
  end

  assign prod_full = PW'(mx) * PW'(my);
  assign prod      = MAG_W'(prod_full);
  assign prod_neg  = (mx_neg ^ my_neg) && (prod != '0);

  logic             p1_neg, p2_neg, den_neg, num_neg;
  logic [MAG_W-1:0] p1_mag, p2_mag, den_mag, num_mag;

  always_ff @(posedge clk) begin
    if (cmd.mul_en) begin
      case (cmd.mul_idx)
        MUL_P1: begin
          p1_mag <= prod; p1_neg <= prod_neg;
        end
        MUL_P2: begin
          p2_mag <= prod; p2_neg <= prod_neg;
        end
        default: begin
          den_mag <= prod; den_neg <= prod_neg;
        end
      endcase
    end
  end

  // Signed sum of the two cross products
  logic             q_neg, s_neg;
  logic [MAG_W-1:0] s_mag;

  always_comb begin
    q_neg = ((func_r == FUNC_SUB) && (p2_mag != '0)) ? ~p2_neg : p2_neg;
    if (p1_neg == q_neg) begin
      s_mag = p1_mag + p2_mag;
      s_neg = p1_neg;
    end else if (p1_mag >= p2_mag) begin
      s_mag = p1_mag - p2_mag;
      s_neg = p1_neg;
    end else begin
      s_mag = p2_mag - p1_mag;
      s_neg = q_neg;
    end
    if (s_mag == '0) s_neg = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.sum_en) begin
      if (is_addsub) begin
        num_mag <= s_mag; num_neg <= s_neg;
      end else begin
        num_mag <= p1_mag; num_neg <= p1_neg;
      end
    end
  end

  // Binary GCD, one subtract or shift per cycle
  logic [MAG_W-1:0]   gu, gv;
  logic [SHIFT_W-1:0] gk;

  always_ff @(posedge clk) begin
    if (cmd.gcd_init) begin
      gu <= num_mag;
      gv <= den_mag;
      gk <= '0;
    end else if (cmd.gcd_en) begin
      if (!gu[0] && !gv[0]) begin
        gu <= gu >> 1;
        gv <= gv >> 1;
        gk <= gk + 1'b1;
      end else if (!gu[0]) begin
        gu <= gu >> 1;
      end else if (!gv[0]) begin
        gv <= gv >> 1;
      end else if (gu >= gv) begin
        gu <= (gu - gv) >> 1;
      end else begin
        gv <= (gv - gu) >> 1;
      end
    end
  end

  // Restoring dividers for numerator and denominator, shared divisor
  logic [MAG_W-1:0]   gdiv, qn, rn, qd, rd;
  logic [SHIFT_W-1:0] div_cnt;
  logic [MAG_W:0]     shn, shd;
  logic               gen, ged;

  assign shn = {rn, qn[MAG_W-1]};
  assign shd = {rd, qd[MAG_W-1]};
  assign gen = shn >= {1'b0, gdiv};
  assign ged = shd >= {1'b0, gdiv};

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      gdiv    <= (gu | gv) << gk;
      qn      <= num_mag;
      qd      <= den_mag;
      rn      <= '0;
      rd      <= '0;
      div_cnt <= SHIFT_W'(MAG_W - 1);
    end else if (cmd.div_en) begin
      qn      <= {qn[MAG_W-2:0], gen};
      qd      <= {qd[MAG_W-2:0], ged};
      rn      <= gen ? MAG_W'(shn - {1'b0, gdiv}) : shn[MAG_W-1:0];
      rd      <= ged ? MAG_W'(shd - {1'b0, gdiv}) : shd[MAG_W-1:0];
      div_cnt <= div_cnt - 1'b1;
    end
  end

  // Result formatting
  logic [MAG_W-1:0]    res_num, an_x;
  logic [DEN_W-1:0]    res_den;
  logic [STATUS_W-1:0] res_st;
  logic                r_neg;

  always_comb begin
    an_x   = MAG_W'(an_mag);
    r_neg  = 1'b0;
    res_st = ST_OK;
    if (func_r[FUNC_W-1]) begin
      r_neg   = (an_neg ^ ad_neg) && (an_mag != '0);
      res_num = r_neg ? -an_x : an_x;
      res_den = DEN_W'(ad_mag);
      res_st  = (ad_mag == '0) ? ST_ZERO_DEN : ST_OK;
    end else if (den_mag == '0) begin
      res_num = (num_mag != '0) ? MAG_W'(1) : '0;
      res_den = '0;
      res_st  = ST_ZERO_DEN;
    end else begin
      r_neg   = (num_neg ^ den_neg) && (qn != '0);
      res_den = qd[DEN_W-1:0];
      if (r_neg) begin
        res_num = -qn;
      end else if (qn[MAG_W-1]) begin
        res_num = {1'b0, {(MAG_W-1){1'b1}}};
        res_st  = ST_OVF;
      end else begin
        res_num = qn;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_data <= OUT_DATA_W'({res_den, res_num});
      out_user <= res_st;
    end
  end

  // Status to controller
  assign sts.is_show  = func_r[FUNC_W-1];
  assign sts.den_zero = (den_mag == '0);
  assign sts.gcd_done = (gu == '0) || (gv == '0);
  assign sts.div_last = (div_cnt == '0);
  assign sts.out_busy = out_valid && !out_ready;

endmodule

`default_nettype wire

@@ design/rational_arithmetic_unit.sv @@
// ----------------------------------------------------------------------------
// rational_arithmetic_unit: signed rational add/sub/mul/div with reduction
// Forms exact cross products, reduces by GCD and sign-normalizes the result.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel s_*: one item holds two rationals a_num/a_den, b_num/b_den
//   in s_tdata and the operation code in s_tuser. Output channel m_*: one
//   result item per input item, reduced numerator and denominator in m_tdata,
//   status in m_tuser (ok, zero denominator, numerator overflow).
//   Show and zero-denominator items skip the GCD and divide steps; other
//   items run the binary GCD, one subtract or shift per cycle, and then
//   the bit-serial divide of numerator and denominator, run side by side.
//   One item is processed at a time; s_tready is high only while idle.
//   A finished result waits in the output register, and the next item is
//   accepted meanwhile; if m_tready stays low, the next result holds in the
//   sequencer until the register frees.
//   Reset (rst, synchronous) returns the sequencer to idle and drops m_tvalid.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit #(
  parameter int OPERAND_WIDTH = rau_pkg::OPERAND_WIDTH_DEF
) (
  input  wire                             clk,
  input  wire                             rst,
  input  wire                             s_tvalid,
  output logic                            s_tready,
  input  wire [rau_pkg::IN_DATA_W-1:0]    s_tdata,  // a_num, a_den, b_num, b_den
  input  wire [rau_pkg::FUNC_W-1:0]       s_tuser,  // func
  output logic                            m_tvalid,
  input  wire                             m_tready,
  output logic [rau_pkg::OUT_DATA_W-1:0]  m_tdata,  // res_num, res_den, zero pad
  output logic [rau_pkg::STATUS_W-1:0]    m_tuser   // status
);
  import rau_pkg::*;

  cmd_t cmd;
  sts_t sts;

  rau_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .in_ready (s_tready),
    .sts      (sts),
    .cmd      (cmd)
  );

  rau_dp #(
    .OPERAND_WIDTH (OPERAND_WIDTH)
  ) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_func   (s_tuser),
    .in_data   (s_tdata),
    .cmd       (cmd),
    .sts       (sts),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_data  (m_tdata),
    .out_user  (m_tuser)
  );

endmodule

`default_nettype wire
